FILE: hw/rtl/backlight_pwm_fade_ramp_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the backlight fade ramp
// Clocked assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BACKLIGHT_PWM_FADE_RAMP_ASSERT_SVH
`define BACKLIGHT_PWM_FADE_RAMP_ASSERT_SVH

`ifndef SYNTHESIS
// plain clocked property, disabled during reset
`define BPFR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpfr assertion failed");
// same-cycle implication, disabled during reset
`define BPFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpfr implication failed");
`else
`define BPFR_ASSERT(label, clk, rst_n, prop)
`define BPFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/bpfr_pkg.sv
// ----------------------------------------------------------------------------
// Backlight fade ramp package
// Shared types, constants and helper functions for the duty fader.
// ----------------------------------------------------------------------------
package bpfr_pkg;

    // duty and ramp limits
    localparam logic [15:0] DUTY_MAX       = 16'd1023;
    localparam int          MAX_STEPS_LOG2 = 7;
    localparam logic [10:0] MAX_STEPS      = 11'(1 << MAX_STEPS_LOG2);
    localparam logic [3:0]  TENTHS         = 4'd10;
    localparam logic [7:0]  CNT_MAX        = 8'hFF;

    // reciprocal of ten for 16-bit dividends: q = (x * 52429) >> 19
    localparam logic [31:0] RECIP10        = 32'd52429;
    localparam int          RECIP10_SHIFT  = 19;

    // item kinds
    localparam logic KIND_SET  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // set command status
    typedef enum logic [1:0] {
        SET_NONE = 2'd0,
        SET_RAMP = 2'd1,
        SET_JUMP = 2'd2
    } t_set_status;

    typedef struct packed {
        logic       kind;
        logic [7:0] target_high;
        logic [7:0] target_low;
        logic       fade_enable;
    } t_item;

    typedef struct packed {
        t_set_status set_status;
        logic        duty_updated;
        logic [10:0] duty;
        logic        running;
    } t_result;

    // exact divide by ten of a 16-bit value, low 11 bits of the quotient
    function automatic logic [10:0] div10(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * RECIP10;
        return prod[RECIP10_SHIFT +: 11];
    endfunction

endpackage

FILE: hw/rtl/bpfr_item_if.sv
// ----------------------------------------------------------------------------
// Fade ramp input channel
// Valid/ready channel that carries one set or tick item per transfer.
// ----------------------------------------------------------------------------
interface bpfr_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] target_high;
    logic [7:0] target_low;
    logic       fade_enable;

    modport source (
        output valid, kind, target_high, target_low, fade_enable,
        input  ready
    );
    modport sink (
        input  valid, kind, target_high, target_low, fade_enable,
        output ready
    );
endinterface

FILE: hw/rtl/bpfr_result_if.sv
// ----------------------------------------------------------------------------
// Fade ramp result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface bpfr_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  set_status;
    logic        duty_updated;
    logic [10:0] duty;
    logic        running;

    modport source (
        output valid, set_status, duty_updated, duty, running,
        input  ready
    );
    modport sink (
        input  valid, set_status, duty_updated, duty, running,
        output ready
    );
endinterface

FILE: hw/rtl/backlight_pwm_fade_ramp.sv
// ----------------------------------------------------------------------------
// Backlight PWM fade ramp
// Duty fader that ramps or jumps to a new brightness target on timer ticks.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries set commands (kind 0: target bytes and fade enable) and
//   timer ticks (kind 1). Every accepted item gives exactly one result on
//   o_result: the set status, whether the tick drove a new duty, the duty
//   after the item and the running flag.
//   An item is registered in the input register on transfer, worked by the
//   core and lands in the result register, where it is held until taken.
//   One item per cycle is accepted back to back while the receiver takes
//   results. When the receiver stalls, the result register holds and the
//   input register still takes one more item; past that, i_item.ready drops
//   until the result is taken.
//   Reset (synchronous, active low) clears the duty, the ramp state and both
//   valid flags; no results are pending after reset.
// ----------------------------------------------------------------------------
module backlight_pwm_fade_ramp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bpfr_item_if.sink     i_item,
    bpfr_result_if.source o_result
);
    import bpfr_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;
    logic    in_xfer;

    // pipeline control
    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_xfer      = i_item.valid && i_item.ready;

    // input register valid and result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.kind        <= i_item.kind;
            r_in.target_high <= i_item.target_high;
            r_in.target_low  <= i_item.target_low;
            r_in.fade_enable <= i_item.fade_enable;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    // ramp state and item processing
    bpfr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_result  (core_result)
    );

    // result channel
    assign o_result.valid        = r_out_valid;
    assign o_result.set_status   = r_out.set_status;
    assign o_result.duty_updated = r_out.duty_updated;
    assign o_result.duty         = r_out.duty;
    assign o_result.running      = r_out.running;

endmodule

FILE: hw/rtl/bpfr_core.sv
// ----------------------------------------------------------------------------
// Fade ramp core
// Holds the ramp state and works one item per advance strobe.
// ----------------------------------------------------------------------------
`include "backlight_pwm_fade_ramp_assert.svh"

module bpfr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  bpfr_pkg::t_item   i_item,
    output bpfr_pkg::t_result o_result
);
    import bpfr_pkg::*;

    // ramp state; the ramp base is kept in tenths, the step offset accumulates
    logic [10:0] r_cur,   n_cur;
    logic [13:0] r_base,  n_base;
    logic [15:0] r_delta, n_delta;
    logic [9:0]  r_tgt,   n_tgt;
    logic [6:0]  r_inc,   n_inc;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_cnt,   n_cnt;
    logic        r_down,  n_down;
    logic        r_run,   n_run;

    logic [15:0] merged;
    logic [9:0]  tgt_clamp;
    logic [10:0] tgt_ext;
    logic [10:0] tgt_wide;
    logic [10:0] diff;
    logic [11:0] diff_p1;
    logic [15:0] diff_tenths;
    logic [14:0] cur_tenths;
    logic [15:0] base_ext;
    logic [15:0] ramp_sum;
    logic [10:0] ramp_val;
    logic        is_tick;

    // target merge, clamp and distance to the present duty
    always_comb begin
        merged      = {i_item.target_high, i_item.target_low};
        tgt_clamp   = (merged >= DUTY_MAX) ? 10'(DUTY_MAX) : merged[9:0];
        tgt_ext     = {1'b0, tgt_clamp};
        diff        = (tgt_ext > r_cur) ? (tgt_ext - r_cur) : (r_cur - tgt_ext);
        diff_p1     = {1'b0, diff} + 12'd1;
        diff_tenths = 16'(diff_p1) * 16'(TENTHS);
        cur_tenths  = 15'(r_cur) * 15'(TENTHS);
    end

    // ramp point for the present step
    always_comb begin
        base_ext = {2'b00, r_base};
        ramp_sum = r_down ? (base_ext - r_delta) : (base_ext + r_delta);
        if (r_down && (base_ext < r_delta)) begin
            ramp_val = 11'd0;
        end else begin
            ramp_val = div10(ramp_sum);
        end
    end

    assign is_tick  = (i_item.kind == KIND_TICK);
    assign tgt_wide = {1'b0, r_tgt};

    // next state and result for one item
    always_comb begin
        n_cur   = r_cur;
        n_base  = r_base;
        n_delta = r_delta;
        n_tgt   = r_tgt;
        n_inc   = r_inc;
        n_total = r_total;
        n_cnt   = r_cnt;
        n_down  = r_down;
        n_run   = r_run;
        o_result.set_status   = SET_NONE;
        o_result.duty_updated = 1'b0;

        if (!is_tick) begin
            // set command: new target; if it differs, arm a ramp or a jump from the present duty, else stop running
            n_tgt = tgt_clamp;
            if (tgt_ext > r_cur) begin
                n_down = 1'b0;
            end else if (tgt_ext < r_cur) begin
                n_down = 1'b1;
            end
            if (diff != 11'd0) begin
                n_run  = 1'b1;
                n_cnt  = 8'd0;
                n_base = cur_tenths[13:0];
                if (i_item.fade_enable) begin
                    if (diff >= MAX_STEPS) begin
                        n_inc   = 7'(diff_tenths >> MAX_STEPS_LOG2);
                        n_total = 8'(MAX_STEPS);
                    end else begin
                        n_inc   = 7'(TENTHS);
                        n_total = diff[7:0];
                    end
                    o_result.set_status = SET_RAMP;
                end else begin
                    n_inc   = 7'd0;
                    n_total = 8'd0;
                    o_result.set_status = SET_JUMP;
                end
                n_delta = {9'd0, n_inc};
            end else begin
                n_run = 1'b0;
            end
        end else begin
            // timer tick: next ramp step, then the exact target, then idle
            if (r_cnt < r_total) begin
                n_cur   = ramp_val;
                n_run   = 1'b1;
                n_cnt   = r_cnt + 8'd1;
                n_delta = r_delta + {9'd0, r_inc};
                o_result.duty_updated = 1'b1;
            end else if (r_cnt == r_total) begin
                n_cur = tgt_wide;
                n_run = 1'b0;
                if (r_cnt != CNT_MAX) begin
                    n_cnt = r_cnt + 8'd1;
                end
                o_result.duty_updated = 1'b1;
            end else begin
                n_run = 1'b0;
            end
        end

        o_result.duty    = n_cur;
        o_result.running = n_run;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_base  <= '0;
            r_delta <= '0;
            r_tgt   <= '0;
            r_inc   <= '0;
            r_total <= '0;
            r_cnt   <= '0;
            r_down  <= 1'b0;
            r_run   <= 1'b0;
        end else if (i_advance) begin
            r_cur   <= n_cur;
            r_base  <= n_base;
            r_delta <= n_delta;
            r_tgt   <= n_tgt;
            r_inc   <= n_inc;
            r_total <= n_total;
            r_cnt   <= n_cnt;
            r_down  <= n_down;
            r_run   <= n_run;
        end
    end

    // duty stays within one count above full scale
    `BPFR_ASSERT(a_duty_range, i_clk, i_rst_n, (r_cur <= 11'd1024))
    // a tick on the last count lands exactly on the target
    `BPFR_ASSERT(a_final_target, i_clk, i_rst_n, (i_advance && is_tick && (r_cnt == r_total)) |=> (r_cur == tgt_wide))
    // step count never runs more than one past the step total
    `BPFR_ASSERT(a_cnt_bound, i_clk, i_rst_n, (9'(r_cnt) <= (9'(r_total) + 9'd1)))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backlight fade ramp testbench
// Drives set and tick items into the duty fader through valid/ready channels
// with bursty sending and a patterned receiver stall. An item-level predictor
// of the fader works out the result of every accepted item, and each result
// transfer is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
    import bpfr_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bpfr_item_if   item_ch ();
    bpfr_result_if result_ch ();

    backlight_pwm_fade_ramp u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // fader state as the predictor sees it
    logic [10:0] fade_duty;
    logic [10:0] ramp_origin;
    logic [9:0]  fade_target;
    logic [6:0]  fade_inc;
    logic [7:0]  fade_total;
    logic [7:0]  fade_count;
    logic        fade_down;
    logic        fade_restart;
    logic        fade_running;

    t_result duty_results_due [$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      quiet_cycles = 0;
    int      burst_left   = 0;
    bit      sender_gaps_on = 1'b1;
    int      rx_stall_left = 0;
    logic [15:0] cycle_count = '0;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicts the result of one item and advances the fader state
    function automatic t_result advance_fader(input t_item it);
        t_result     r;
        logic [15:0] merged;
        logic [10:0] diff;
        int unsigned base;
        int unsigned delta;
        int unsigned inc_calc;
        r.set_status   = SET_NONE;
        r.duty_updated = 1'b0;
        if (it.kind == KIND_SET) begin
            merged = {it.target_high, it.target_low};
            if (merged >= DUTY_MAX) merged = DUTY_MAX;
            fade_target = merged[9:0];
            diff = '0;
            if ({1'b0, fade_target} > fade_duty) begin
                diff = {1'b0, fade_target} - fade_duty;
                fade_down = 1'b0;
            end else if ({1'b0, fade_target} < fade_duty) begin
                diff = fade_duty - {1'b0, fade_target};
                fade_down = 1'b1;
            end
            if (diff != '0) begin
                fade_running = 1'b1;
                fade_restart = 1'b1;
                if (it.fade_enable) begin
                    if (diff >= MAX_STEPS) begin
                        inc_calc   = ((int'(diff) + 1) * int'(TENTHS)) / int'(MAX_STEPS);
                        fade_inc   = inc_calc[6:0];
                        fade_total = MAX_STEPS[7:0];
                    end else begin
                        fade_inc   = 7'(TENTHS);
                        fade_total = diff[7:0];
                    end
                    r.set_status = SET_RAMP;
                end else begin
                    fade_inc     = '0;
                    fade_total   = '0;
                    r.set_status = SET_JUMP;
                end
            end else begin
                fade_running = 1'b0;
            end
        end else begin
            if (fade_restart) begin
                fade_count  = '0;
                ramp_origin = fade_duty;
            end
            if (fade_count < fade_total) begin
                // linear step in tenths, floored at zero on the way down
                base  = int'(ramp_origin) * int'(TENTHS);
                delta = (int'(fade_count) + 1) * int'(fade_inc);
                if (!fade_down)
                    fade_duty = 11'((base + delta) / int'(TENTHS));
                else if (base >= delta)
                    fade_duty = 11'((base - delta) / int'(TENTHS));
                else
                    fade_duty = '0;
                fade_running   = 1'b1;
                r.duty_updated = 1'b1;
                fade_count     = fade_count + 8'd1;
            end else if (fade_count == fade_total) begin
                fade_duty      = {1'b0, fade_target};
                fade_running   = 1'b0;
                r.duty_updated = 1'b1;
                if (fade_count < CNT_MAX) fade_count = fade_count + 8'd1;
            end else begin
                fade_running = 1'b0;
            end
            fade_restart = 1'b0;
        end
        r.duty    = fade_duty;
        r.running = fade_running;
        return r;
    endfunction

    function automatic t_item set_item(input logic [15:0] level, input logic fade);
        t_item it;
        it.kind        = KIND_SET;
        it.target_high = level[15:8];
        it.target_low  = level[7:0];
        it.fade_enable = fade;
        return it;
    endfunction

    // tick payload is ignored by the block, so it carries random bits
    function automatic t_item tick_item();
        t_item it;
        it.kind        = KIND_TICK;
        it.target_high = 8'($urandom_range(0, 255));
        it.target_low  = 8'($urandom_range(0, 255));
        it.fade_enable = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic pause_sender(input int cycles);
        item_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // one input transfer, then maybe a gap between bursts
    task automatic send_item(input t_item it);
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= it.kind;
        item_ch.target_high <= it.target_high;
        item_ch.target_low  <= it.target_low;
        item_ch.fade_enable <= it.fade_enable;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        duty_results_due.push_back(advance_fader(it));
        items_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (sender_gaps_on) pause_sender($urandom_range(1, 10));
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_for_results();
        pause_sender(1);
        while (duty_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input int unsigned expv,
                                 input int unsigned actv);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, expv, actv);
        mismatches++;
    endtask

    // check each result transfer, track quiet cycles, drive receiver stalls
    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (duty_results_due.size() == 0) begin
                    $display("%0t ns: result with none expected, actual duty %0d",
                             $time, result_ch.duty);
                    mismatches++;
                end else begin
                    due = duty_results_due.pop_front();
                    if (result_ch.set_status !== due.set_status)
                        note_mismatch("set_status", due.set_status, result_ch.set_status);
                    if (result_ch.duty_updated !== due.duty_updated)
                        note_mismatch("duty_updated", due.duty_updated, result_ch.duty_updated);
                    if (result_ch.duty !== due.duty)
                        note_mismatch("duty", due.duty, result_ch.duty);
                    if (result_ch.running !== due.running)
                        note_mismatch("running", due.running, result_ch.running);
                end
            end
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        // stall pattern follows bits 9:8 of the cycle counter
        cycle_count <= cycle_count + 16'd1;
        case (cycle_count[9:8])
            2'd0: result_ch.ready <= 1'b1;
            2'd1: result_ch.ready <= 1'($urandom_range(0, 1));
            2'd2: result_ch.ready <= (cycle_count[1:0] != 2'd0);
            default: begin
                if (rx_stall_left > 0) begin
                    rx_stall_left   <= rx_stall_left - 1;
                    result_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    rx_stall_left   <= $urandom_range(1, 10);
                    result_ch.ready <= 1'b0;
                end else begin
                    result_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    // watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    // field extremes, clamping, jumps, ramps, equal target, restart, idle ticks
    task automatic test_directed();
        send_item(tick_item());                         // first tick drives target zero
        send_item(tick_item());                         // idle tick
        send_item(set_item(16'h0000, 1'b1));            // equal target
        send_item(set_item(16'h03FF, 1'b0));            // jump to full scale
        send_item(tick_item());
        send_item(tick_item());
        send_item(set_item(16'hFFFF, 1'b1));            // clamps to full scale, no change
        send_item(set_item(16'h0200, 1'b1));            // long ramp down
        send_item(tick_item());
        send_item(tick_item());
        send_item(set_item({5'd0, fade_duty}, 1'b1));   // equal target keeps ramp armed
        send_item(tick_item());
        send_item(set_item({5'd0, fade_duty} + 16'd5, 1'b1)); // short ramp, restarts
        repeat (7) send_item(tick_item());
        send_item(set_item(16'h0000, 1'b0));            // jump to zero
        send_item(tick_item());
        send_item(set_item(16'hAA55, 1'b1));            // clamped ramp target
        send_item(tick_item());
    endtask

    // full-scale ramps: overshoot going up, floor at zero going down
    task automatic test_full_scale();
        sender_gaps_on = 1'b0;
        send_item(set_item(16'h0000, 1'b0));
        send_item(tick_item());
        send_item(set_item(16'h03FF, 1'b1));
        repeat (131) send_item(tick_item());
        send_item(set_item(16'h0000, 1'b1));
        repeat (131) send_item(tick_item());
        sender_gaps_on = 1'b1;
    endtask

    // well-formed set-then-ticks sequences with random targets
    task automatic test_fade_sequences(input int goal);
        int          pick;
        int          level;
        int          ticks;
        logic        fade;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 11);
            case (pick)
                0, 1, 2, 3: begin
                    level = int'(fade_duty) + ($urandom_range(0, 1) ? 1 : -1)
                            * int'($urandom_range(1, 127));
                    if (level < 0) level = 0;
                    if (level > 1023) level = 1023;
                end
                7: level = int'($urandom_range(0, 16'hFFFF));
                8: level = int'(fade_duty);
                9: level = $urandom_range(0, 1) ? 1023 : 0;
                default: level = int'($urandom_range(0, 1023));
            endcase
            fade = ($urandom_range(0, 4) != 0);
            send_item(set_item(16'(level), fade));
            ticks = int'(fade_total) + 1 + int'($urandom_range(0, 2));
            if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, int'(fade_total));
            repeat (ticks) send_item(tick_item());
        end
    endtask

    // unstructured items, any kind and any payload
    task automatic test_random_items(input int count);
        t_item it;
        repeat (count) begin
            it = tick_item();
            it.kind = 1'($urandom_range(0, 1));
            send_item(it);
        end
    endtask

    // sender holds off until every result is in, then resumes
    task automatic test_drain_pause();
        repeat (4) begin
            send_item(set_item(16'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))));
            repeat (4) send_item(tick_item());
            wait_for_results();
            pause_sender($urandom_range(1, 20));
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.kind        <= KIND_SET;
        item_ch.target_high <= '0;
        item_ch.target_low  <= '0;
        item_ch.fade_enable <= 1'b0;
        fade_duty    = '0;
        ramp_origin  = '0;
        fade_target  = '0;
        fade_inc     = '0;
        fade_total   = '0;
        fade_count   = '0;
        fade_down    = 1'b0;
        fade_restart = 1'b0;
        fade_running = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_scale();
        test_fade_sequences(900);
        test_drain_pause();
        test_fade_sequences(1480);
        test_random_items(170);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
